/* src/bounded_fifo_search_remove_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the bounded FIFO with search and remove
// Shared concurrent checks, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_FIFO_SEARCH_REMOVE_DEFINES_SVH
`define BOUNDED_FIFO_SEARCH_REMOVE_DEFINES_SVH

// Same-cycle implication.
`define BFSR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BFSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/bfsr_pkg.sv */
// ----------------------------------------------------------------------------
// bfsr_pkg
// Types and constants shared by the queue controller, datapath and top level.
// ----------------------------------------------------------------------------
package bfsr_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = 6;
  localparam int CNT_W  = 7;
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;
  localparam int VAL_W  = 31;
  localparam int SEC_W  = 32;
  localparam int MIC_W  = 20;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ    = 2'd0,
    CMD_DEQ    = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_REMOVE = 2'd3
  } cmd_code_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [SEC_W-1:0] seconds;
    logic [MIC_W-1:0] micros;
  } entry_t;

  // Controller -> datapath
  typedef struct packed {
    logic    capture_in;
    logic    res_clr;
    logic    res_status_wr;
    status_t res_status;
    logic    wr_enq;
    logic    wr_shift;
    logic    rd_idx;
    logic    rd_head;
    logic    idx_clr;
    logic    idx_pos;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    head_inc;
    logic    val_cap;
    logic    found_cap;
    logic    out_load;
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    cmd_code_t cmd;
    logic      empty;
    logic      full;
    logic      pos_bad;
    logic      idx_more;
    logic      match;
  } dp_stat_t;

endpackage

/* src/bfsr_ram.sv */
// ----------------------------------------------------------------------------
// bfsr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/bfsr_ctrl.sv */
// ----------------------------------------------------------------------------
// bfsr_ctrl
// Command sequencer: dispatches each request and steps the entry memory.
// ----------------------------------------------------------------------------
module bfsr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  bfsr_pkg::dp_stat_t   stat,
  output bfsr_pkg::ctrl_cmd_t  cmd
);
  import bfsr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_DEQ_RD,
    S_DEQ_CAP,
    S_FIND_RUN,
    S_RM_RD,
    S_RM_FIRST,
    S_RM_SHIFT,
    S_HEAD_RD,
    S_HEAD_CAP
  } state_t;

  state_t state, state_next;
  logic   pend, pend_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.res_status = ST_OK;
    state_next = state;
    pend_next  = pend;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture_in = 1'b1;
          state_next     = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.res_clr = 1'b1;
        state_next  = S_HEAD_RD;
        if (stat.cmd == CMD_ENQ) begin
          if (stat.full) begin
            cmd.res_status_wr = 1'b1;
            cmd.res_status    = ST_FULL;
          end else begin
            cmd.wr_enq  = 1'b1;
            cmd.cnt_inc = 1'b1;
          end
        end else if (stat.empty) begin
          cmd.res_status_wr = 1'b1;
          cmd.res_status    = ST_EMPTY;
        end else begin
          case (stat.cmd)
            CMD_DEQ: state_next = S_DEQ_RD;
            CMD_FIND: begin
              cmd.idx_clr = 1'b1;
              pend_next   = 1'b0;
              state_next  = S_FIND_RUN;
            end
            CMD_REMOVE: begin
              if (stat.pos_bad) begin
                cmd.res_status_wr = 1'b1;
                cmd.res_status    = ST_MISS;
              end else begin
                cmd.idx_pos = 1'b1;
                state_next  = S_RM_RD;
              end
            end
            default: state_next = S_HEAD_RD;
          endcase
        end
      end
      S_DEQ_RD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_DEQ_CAP;
      end
      S_DEQ_CAP: begin
        cmd.val_cap  = 1'b1;
        cmd.head_inc = 1'b1;
        cmd.cnt_dec  = 1'b1;
        state_next   = S_HEAD_RD;
      end
      S_FIND_RUN: begin
        // compare the entry read last cycle while the next read goes out
        if (pend && stat.match) begin
          cmd.found_cap = 1'b1;
          state_next    = S_HEAD_RD;
        end else if (stat.idx_more) begin
          cmd.rd_idx = 1'b1;
          pend_next  = 1'b1;
        end else begin
          cmd.res_status_wr = 1'b1;
          cmd.res_status    = ST_MISS;
          state_next        = S_HEAD_RD;
        end
      end
      S_RM_RD: begin
        cmd.rd_idx = 1'b1;
        state_next = S_RM_FIRST;
      end
      S_RM_FIRST: begin
        cmd.val_cap = 1'b1;
        if (stat.idx_more) begin
          cmd.rd_idx = 1'b1;
          state_next = S_RM_SHIFT;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_HEAD_RD;
        end
      end
      S_RM_SHIFT: begin
        // write back the entry read last cycle one place toward the head
        cmd.wr_shift = 1'b1;
        if (stat.idx_more) begin
          cmd.rd_idx = 1'b1;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_HEAD_CAP;
      end
      S_HEAD_CAP: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/bfsr_dp.sv */
// ----------------------------------------------------------------------------
// bfsr_dp
// Queue datapath: entry memory, head/count/limit registers, result registers.
// ----------------------------------------------------------------------------
`include "bounded_fifo_search_remove_defines.svh"

module bfsr_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bfsr_pkg::ctrl_cmd_t           cmd,
  output bfsr_pkg::dp_stat_t            stat,
  input  logic                          cfg_we,
  input  logic [bfsr_pkg::CNT_W-1:0]    cfg_data,
  input  logic [bfsr_pkg::CMD_W-1:0]    command,
  input  logic [bfsr_pkg::VAL_W-1:0]    item_value,
  input  logic [bfsr_pkg::SEC_W-1:0]    arrival_seconds,
  input  logic [bfsr_pkg::MIC_W-1:0]    arrival_micros,
  input  logic [bfsr_pkg::ADDR_W-1:0]   position,
  output logic [bfsr_pkg::ST_W-1:0]     status,
  output logic [bfsr_pkg::VAL_W-1:0]    out_value,
  output logic [bfsr_pkg::ADDR_W-1:0]   found_index,
  output logic [bfsr_pkg::CNT_W-1:0]    entry_count,
  output logic [bfsr_pkg::SEC_W-1:0]    head_seconds,
  output logic [bfsr_pkg::MIC_W-1:0]    head_micros
);
  import bfsr_pkg::*;

  // control state
  logic [CNT_W-1:0]  max_entries;
  logic [ADDR_W-1:0] head;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  widx;

  // captured request
  cmd_code_t         cmd_q;
  logic [VAL_W-1:0]  val_q;
  logic [SEC_W-1:0]  sec_q;
  logic [MIC_W-1:0]  mic_q;
  logic [ADDR_W-1:0] pos_q;

  // working result
  status_t           res_status;
  logic [VAL_W-1:0]  res_value;
  logic [ADDR_W-1:0] res_found;

  logic [CNT_W-1:0]  limit_eff;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] h,
                                                input logic [CNT_W-1:0] p);
    logic [CNT_W:0] s;
    s = {2'b00, h} + {1'b0, p};
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

  assign limit_eff = (max_entries > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : max_entries;

  assign stat.cmd      = cmd_q;
  assign stat.empty    = (count == '0);
  assign stat.full     = (count >= limit_eff);
  assign stat.pos_bad  = ({1'b0, pos_q} >= count);
  assign stat.idx_more = (idx < count);
  assign stat.match    = (ram_rdata.value == val_q);

  assign ram_re    = cmd.rd_idx | cmd.rd_head;
  assign ram_raddr = cmd.rd_head ? head : slot_of(head, idx);
  assign ram_we    = cmd.wr_enq | cmd.wr_shift;
  assign ram_waddr = cmd.wr_shift ? slot_of(head, widx) : slot_of(head, count);
  assign ram_wdata = cmd.wr_shift ? ram_rdata : entry_t'{val_q, sec_q, mic_q};

  bfsr_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= CNT_W'(DEPTH);
      head        <= '0;
      count       <= '0;
    end else begin
      if (cfg_we) begin
        max_entries <= cfg_data;
      end
      if (cmd.head_inc) begin
        head <= slot_of(head, CNT_W'(1));
      end
      if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_in) begin
      cmd_q <= cmd_code_t'(command);
      val_q <= item_value;
      sec_q <= arrival_seconds;
      mic_q <= arrival_micros;
      pos_q <= position;
    end
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_pos) begin
      idx <= {1'b0, pos_q};
    end else if (cmd.rd_idx) begin
      idx <= idx + 1'b1;
    end
    if (cmd.idx_pos) begin
      widx <= {1'b0, pos_q};
    end else if (cmd.wr_shift) begin
      widx <= widx + 1'b1;
    end
    if (cmd.res_status_wr) begin
      res_status <= cmd.res_status;
    end else if (cmd.res_clr) begin
      res_status <= ST_OK;
    end
    if (cmd.res_clr) begin
      res_value  <= '0;
      res_found  <= '0;
    end
    if (cmd.val_cap) begin
      res_value <= ram_rdata.value;
    end
    if (cmd.found_cap) begin
      // the matching entry was read from the position before idx
      res_found <= ADDR_W'(idx - 1'b1);
    end
    if (cmd.out_load) begin
      status       <= res_status;
      out_value    <= res_value;
      found_index  <= res_found;
      entry_count  <= count;
      head_seconds <= (count == '0) ? '0 : ram_rdata.seconds;
      head_micros  <= (count == '0) ? '0 : ram_rdata.micros;
    end
  end

  `BFSR_ASSERT_IMPL(a_cnt_bound, 1'b1, count <= CNT_W'(DEPTH), "count above depth")
  `BFSR_ASSERT_IMPL(a_enq_limit, cmd.cnt_inc, count < limit_eff, "enqueue past limit")
  `BFSR_ASSERT_IMPL(a_dec_nonempty, cmd.cnt_dec, count != '0, "removal from empty queue")
  `BFSR_ASSERT_IMPL(a_shift_order, cmd.wr_shift, widx < idx, "shift write ahead of read")
  `BFSR_ASSERT_NEXT(a_one_change, cmd.cnt_inc || cmd.cnt_dec,
                    count != $past(count), "count did not move")

endmodule

/* src/bounded_fifo_search_remove.sv */
// ----------------------------------------------------------------------------
// bounded_fifo_search_remove
// Bounded FIFO of timestamped values with enqueue, dequeue, find and
// remove-at-index, one result per request.
// ----------------------------------------------------------------------------
// One request is worked at a time, through a single entry memory that does
// one read and one write per cycle. Find compares entries from the head, up
// to the count, until one matches; remove at position p moves the entries
// behind p one place toward the head, one per cycle. The next request is
// taken as soon as the previous result sits in the output register.
// The limit register may be changed only while no request is in flight.
module bounded_fifo_search_remove (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bfsr_pkg::CMD_W-1:0]    command,
  input  logic [bfsr_pkg::VAL_W-1:0]    item_value,
  input  logic [bfsr_pkg::SEC_W-1:0]    arrival_seconds,
  input  logic [bfsr_pkg::MIC_W-1:0]    arrival_micros,
  input  logic [bfsr_pkg::ADDR_W-1:0]   position,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bfsr_pkg::ST_W-1:0]     status,
  output logic [bfsr_pkg::VAL_W-1:0]    out_value,
  output logic [bfsr_pkg::ADDR_W-1:0]   found_index,
  output logic [bfsr_pkg::CNT_W-1:0]    entry_count,
  output logic [bfsr_pkg::SEC_W-1:0]    head_seconds,
  output logic [bfsr_pkg::MIC_W-1:0]    head_micros,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfsr_pkg::CNT_W-1:0]    cfg_data
);
  import bfsr_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  bfsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfsr_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_data        (cfg_data),
    .command         (command),
    .item_value      (item_value),
    .arrival_seconds (arrival_seconds),
    .arrival_micros  (arrival_micros),
    .position        (position),
    .status          (status),
    .out_value       (out_value),
    .found_index     (found_index),
    .entry_count     (entry_count),
    .head_seconds    (head_seconds),
    .head_micros     (head_micros)
  );

endmodule
